FILE: rtl/slu_pkg.sv
// Shared types and constants for the source character lexer.
`default_nettype none
package slu_pkg;

    localparam int POSITION_BITS = 24;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] K_INT    = 4'd0;
    localparam logic [3:0] K_UINT8  = 4'd1;
    localparam logic [3:0] K_IDENT  = 4'd2;
    localparam logic [3:0] K_NUM    = 4'd3;
    localparam logic [3:0] K_SEMI   = 4'd4;
    localparam logic [3:0] K_QEQ    = 4'd5;
    localparam logic [3:0] K_ASSIGN = 4'd6;
    localparam logic [3:0] K_SPREAD = 4'd7;
    localparam logic [3:0] K_LBR    = 4'd8;
    localparam logic [3:0] K_RBR    = 4'd9;
    localparam logic [3:0] K_PLUSEQ = 4'd10;
    localparam logic [3:0] K_PLUS   = 4'd11;
    localparam logic [3:0] K_DIV    = 4'd12;
    localparam logic [3:0] K_ERR    = 4'd13;
    localparam logic [3:0] K_EOF    = 4'd14;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        logic [3:0]               token_kind;
        logic [POSITION_BITS-1:0] token_line;
        logic [POSITION_BITS-1:0] start_pos;
        logic [7:0]               token_length;
        logic                     last_of_run;
    } tok_item_t;

    typedef struct packed {
        logic [3:0]               kind;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] start;
        logic [7:0]               length;
    } tok_t;

    typedef struct packed {
        tok_t first;
        tok_t second;
        logic two;
    } entry_t;

endpackage
`default_nettype wire

FILE: rtl/slu_front.sv
// Byte scanner: classifies each request and builds up to two tokens.
`default_nettype none
module slu_front
    import slu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      src_valid,
    output logic           src_stall,
    input  wire src_item_t src_item,
    input  wire logic      q_full,
    output logic           push,
    output entry_t         push_entry
);

    typedef enum logic [9:0] {
        M_IDLE  = 10'b00_0000_0001,
        M_IDENT = 10'b00_0000_0010,
        M_NUM   = 10'b00_0000_0100,
        M_QUEST = 10'b00_0000_1000,
        M_DOT   = 10'b00_0001_0000,
        M_PLUS  = 10'b00_0010_0000,
        M_SLASH = 10'b00_0100_0000,
        M_LINEC = 10'b00_1000_0000,
        M_BLOCK = 10'b01_0000_0000,
        M_STAR  = 10'b10_0000_0000
    } mode_t;

    localparam logic [39:0] WORD_INT   = 40'h00_0074_6E69;
    localparam logic [39:0] WORD_UINT8 = 40'h38_746E_6975;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] pstart_reg, pstart_next;
    logic [POSITION_BITS-1:0] pline_reg, pline_next;
    logic [7:0]               plen_reg, plen_next;
    logic [39:0]              prefix_reg, prefix_next;

    logic       accept;
    logic [7:0] c;
    logic       rescan;
    logic       main_emit, idle_emit;
    tok_t       main_tok, idle_tok, word_tok;
    logic [3:0] word_kind;

    function automatic logic is_alpha(input logic [7:0] b);
        is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        is_space = b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;
    assign c         = src_item.source_byte;

    always_comb
    begin
        if (mode_reg == M_NUM)
            word_kind = K_NUM;
        else if (plen_reg == 8'd3 && prefix_reg == WORD_INT)
            word_kind = K_INT;
        else if (plen_reg == 8'd5 && prefix_reg == WORD_UINT8)
            word_kind = K_UINT8;
        else
            word_kind = K_IDENT;
        word_tok = '{kind: word_kind, line: pline_reg, start: pstart_reg, length: plen_reg};
    end

    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        pos_next    = pos_reg + 1'b1;
        pstart_next = pstart_reg;
        pline_next  = pline_reg;
        plen_next   = plen_reg;
        prefix_next = prefix_reg;
        rescan      = 1'b0;
        main_emit   = 1'b0;
        main_tok    = '{kind: K_PLUS, line: pline_reg, start: pstart_reg, length: 8'd1};
        idle_emit   = 1'b0;
        idle_tok    = '{kind: K_ERR, line: line_reg, start: pos_reg, length: 8'd1};

        if (src_item.end_of_input)
        begin
            unique case (mode_reg)
                M_IDENT, M_NUM:
                begin
                    main_emit = 1'b1;
                    main_tok  = word_tok;
                end
                M_PLUS:  main_emit = 1'b1;
                M_SLASH:
                begin
                    main_emit     = 1'b1;
                    main_tok.kind = K_DIV;
                end
                default: ;
            endcase
            idle_emit   = 1'b1;
            idle_tok    = '{kind: K_EOF, line: line_reg, start: pos_reg, length: 8'd0};
            mode_next   = M_IDLE;
            line_next   = POSITION_BITS'(1);
            pos_next    = '0;
            pstart_next = '0;
            pline_next  = POSITION_BITS'(1);
            plen_next   = '0;
            prefix_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c) || c == "_")
                    begin
                        if (plen_reg < 8'd5)
                            prefix_next = prefix_reg | (40'(c) << {plen_reg[2:0], 3'b000});
                        if (plen_reg != 8'hFF)
                            plen_next = plen_reg + 1'b1;
                    end
                    else
                    begin
                        main_emit = 1'b1;
                        main_tok  = word_tok;
                        rescan    = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit(c))
                    begin
                        if (plen_reg != 8'hFF)
                            plen_next = plen_reg + 1'b1;
                    end
                    else
                    begin
                        main_emit = 1'b1;
                        main_tok  = word_tok;
                        rescan    = 1'b1;
                    end
                end
                M_QUEST, M_DOT, M_PLUS:
                begin
                    if (c == ((mode_reg == M_DOT) ? 8'h2E : 8'h3D))
                    begin
                        main_emit       = 1'b1;
                        main_tok.length = 8'd2;
                        main_tok.kind   = (mode_reg == M_QUEST) ? K_QEQ :
                                          (mode_reg == M_DOT)   ? K_SPREAD : K_PLUSEQ;
                        mode_next       = M_IDLE;
                    end
                    else
                    begin
                        main_emit = (mode_reg == M_PLUS);
                        rescan    = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (c == "/")
                        mode_next = M_LINEC;
                    else if (c == "*")
                        mode_next = M_BLOCK;
                    else
                    begin
                        main_emit     = 1'b1;
                        main_tok.kind = K_DIV;
                        rescan        = 1'b1;
                    end
                end
                M_LINEC:
                begin
                    if (c == 8'h0A)
                        rescan = 1'b1;
                end
                M_BLOCK, M_STAR:
                begin
                    if (mode_reg == M_STAR && c == "/")
                        mode_next = M_IDLE;
                    else if (c == "*")
                        mode_next = M_STAR;
                    else
                    begin
                        if (c == 8'h0A)
                            line_next = line_reg + 1'b1;
                        mode_next = M_BLOCK;
                    end
                end
                default: rescan = 1'b1;
            endcase

            if (rescan)
            begin
                mode_next = M_IDLE;
                if (is_space(c))
                begin
                    if (c == 8'h0A)
                        line_next = line_reg + 1'b1;
                end
                else if (is_alpha(c) || is_digit(c) || c == "?" || c == "." ||
                         c == "+" || c == "/")
                begin
                    pstart_next = pos_reg;
                    pline_next  = line_reg;
                    plen_next   = 8'd1;
                    if (is_alpha(c))
                    begin
                        mode_next   = M_IDENT;
                        prefix_next = 40'(c);
                    end
                    else if (is_digit(c))
                    begin
                        mode_next   = M_NUM;
                        prefix_next = '0;
                    end
                    else if (c == "?")
                        mode_next = M_QUEST;
                    else if (c == ".")
                        mode_next = M_DOT;
                    else if (c == "+")
                        mode_next = M_PLUS;
                    else
                        mode_next = M_SLASH;
                end
                else if (c == "_")
                begin
                    mode_next   = M_IDENT;
                    prefix_next = 40'(c);
                    pstart_next = pos_reg;
                    pline_next  = line_reg;
                    plen_next   = 8'd1;
                end
                else
                begin
                    idle_emit = 1'b1;
                    case (c)
                        ";":     idle_tok.kind = K_SEMI;
                        "=":     idle_tok.kind = K_ASSIGN;
                        "[":     idle_tok.kind = K_LBR;
                        "]":     idle_tok.kind = K_RBR;
                        default: idle_tok.kind = K_ERR;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        push             = accept && (main_emit || idle_emit);
        push_entry.two   = main_emit && idle_emit;
        push_entry.first = main_emit ? main_tok : idle_tok;
        push_entry.second = idle_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            line_reg   <= POSITION_BITS'(1);
            pos_reg    <= '0;
            pstart_reg <= '0;
            pline_reg  <= POSITION_BITS'(1);
            plen_reg   <= '0;
            prefix_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            pline_reg  <= pline_next;
            plen_reg   <= plen_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/slu_queue.sv
// Short queue of token groups between the scanner and the output stage.
`default_nettype none
module slu_queue
    import slu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        head_valid,
    output entry_t      head_entry
);

    entry_t               slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic                 do_pop;

    assign full       = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = slots_reg[rptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/slu_back.sv
// Output stage: splits token groups and holds one token per request.
`default_nettype none
module slu_back
    import slu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   head_valid,
    input  wire entry_t head_entry,
    output logic        pop,
    output logic        tok_valid,
    input  wire logic   tok_stall,
    output tok_item_t   tok_item
);

    logic      out_valid_reg;
    tok_item_t out_reg;
    logic      spare_valid_reg;
    tok_t      spare_reg;
    logic      load;

    function automatic tok_item_t to_item(input tok_t t, input logic last);
        to_item = '{token_kind: t.kind, token_line: t.line, start_pos: t.start,
                    token_length: t.length, last_of_run: last};
    endfunction

    assign load      = !out_valid_reg || !tok_stall;
    assign pop       = load && !spare_valid_reg && head_valid;
    assign tok_valid = out_valid_reg;
    assign tok_item  = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (spare_valid_reg)
                out_reg <= to_item(spare_reg, 1'b1);
            else
                out_reg <= to_item(head_entry.first, !head_entry.two);
        end
        if (pop)
            spare_reg <= head_entry.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg   <= spare_valid_reg || head_valid;
            spare_valid_reg <= !spare_valid_reg && head_valid && head_entry.two;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/source_character_lexer_unit.sv
// Top level of the source character lexer.
// Takes one source byte per request and returns tokens (kind, line, start
// offset, length) one per request on the output side. A byte is accepted every
// cycle while the four-entry token queue has room; a byte that produces two
// tokens leaves as two separate output tokens. The scanner state is a single
// register set updated once per accepted byte; the first token of an accepted
// byte passes through the token queue and then the registered output stage.
`default_nettype none
module source_character_lexer_unit
    import slu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      src_valid,
    output logic           src_stall,
    input  wire src_item_t src_item,
    output logic           tok_valid,
    input  wire logic      tok_stall,
    output tok_item_t      tok_item
);

    logic   q_full;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    slu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_item   (src_item),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    slu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    slu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_item   (tok_item)
    );

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind == K_EOF |-> tok_item.last_of_run)
        else $error("eof token not last of run");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind != K_EOF |-> tok_item.token_length != 8'd0)
        else $error("zero-length token");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_item.last_of_run |=> tok_valid)
        else $error("second token of a pair missing");

    a_two_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.two |-> push_entry.second.kind == K_EOF ||
            push_entry.first.kind == K_IDENT || push_entry.first.kind == K_NUM ||
            push_entry.first.kind == K_INT || push_entry.first.kind == K_UINT8 ||
            push_entry.first.kind == K_PLUS || push_entry.first.kind == K_DIV)
        else $error("unexpected token pair");

endmodule
`default_nettype wire

FILE: tb/sv/source_character_lexer_unit_tb.sv
// Self-checking testbench for the source character lexer: byte stimulus, token prediction, checks.
module source_character_lexer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import slu_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER,
        MODE_QUESTION,
        MODE_DOT,
        MODE_PLUS,
        MODE_SLASH,
        MODE_LINE_COMMENT,
        MODE_BLOCK_COMMENT,
        MODE_BLOCK_STAR
    } scan_mode_t;

    // packed low byte first
    localparam logic [39:0] WORD_INT   = {16'h0, "tni"};
    localparam logic [39:0] WORD_UINT8 = "8tniu";

    class token_ledger;
        scan_mode_t mode;
        logic [POSITION_BITS-1:0] line_count;
        logic [POSITION_BITS-1:0] byte_pos;
        logic [POSITION_BITS-1:0] pend_start;
        logic [POSITION_BITS-1:0] pend_line;
        int pend_len;
        logic [39:0] word_bytes;
        tok_item_t run_q[$];
        tok_item_t pending_tokens[$];
        int errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            mode = MODE_IDLE;
            line_count = 1;
            byte_pos = 0;
            pend_start = 0;
            pend_line = 1;
            pend_len = 0;
            word_bytes = '0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == " " || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function void add_token(logic [3:0] kind, logic [POSITION_BITS-1:0] line,
                                logic [POSITION_BITS-1:0] start, int len);
            tok_item_t t;
            t.token_kind   = kind;
            t.token_line   = line;
            t.start_pos    = start;
            t.token_length = (len > 255) ? 8'd255 : 8'(len);
            t.last_of_run  = 1'b0;
            run_q.push_back(t);
        endfunction

        function void open_token(scan_mode_t m);
            mode = m;
            pend_start = byte_pos;
            pend_line = line_count;
            pend_len = 1;
        endfunction

        function void flush_word();
            logic [3:0] kind;
            kind = K_IDENT;
            if (mode == MODE_NUMBER)
                kind = K_NUM;
            else if (pend_len == 3 && word_bytes == WORD_INT)
                kind = K_INT;
            else if (pend_len == 5 && word_bytes == WORD_UINT8)
                kind = K_UINT8;
            add_token(kind, pend_line, pend_start, pend_len);
        endfunction

        function void scan_fresh(logic [7:0] c);
            mode = MODE_IDLE;
            if (is_blank(c))
            begin
                if (c == 8'h0A)
                    line_count++;
            end
            else if (is_letter(c) || c == "_")
            begin
                open_token(MODE_WORD);
                word_bytes = 40'(c);
            end
            else if (is_digit(c))
            begin
                open_token(MODE_NUMBER);
                word_bytes = '0;
            end
            else
            begin
                case (c)
                    ";": add_token(K_SEMI, line_count, byte_pos, 1);
                    "=": add_token(K_ASSIGN, line_count, byte_pos, 1);
                    "[": add_token(K_LBR, line_count, byte_pos, 1);
                    "]": add_token(K_RBR, line_count, byte_pos, 1);
                    "?": open_token(MODE_QUESTION);
                    ".": open_token(MODE_DOT);
                    "+": open_token(MODE_PLUS);
                    "/": open_token(MODE_SLASH);
                    default: add_token(K_ERR, line_count, byte_pos, 1);
                endcase
            end
        endfunction

        function void note_byte(src_item_t it);
            logic [7:0] c;
            logic [7:0] follow;
            logic [3:0] kind;
            bit rescan;
            tok_item_t t;
            c = it.source_byte;
            rescan = 1'b0;
            run_q.delete();
            if (it.end_of_input)
            begin
                case (mode)
                    MODE_WORD, MODE_NUMBER: flush_word();
                    MODE_PLUS: add_token(K_PLUS, pend_line, pend_start, 1);
                    MODE_SLASH: add_token(K_DIV, pend_line, pend_start, 1);
                    default: ;
                endcase
                add_token(K_EOF, line_count, byte_pos, 0);
                restart();
            end
            else
            begin
                case (mode)
                    MODE_WORD:
                    begin
                        if (is_letter(c) || is_digit(c) || c == "_")
                        begin
                            if (pend_len < 5)
                                word_bytes |= 40'(c) << (8 * pend_len);
                            if (pend_len < 255)
                                pend_len++;
                        end
                        else
                        begin
                            flush_word();
                            rescan = 1'b1;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit(c))
                        begin
                            if (pend_len < 255)
                                pend_len++;
                        end
                        else
                        begin
                            flush_word();
                            rescan = 1'b1;
                        end
                    end
                    MODE_QUESTION, MODE_DOT, MODE_PLUS:
                    begin
                        follow = (mode == MODE_DOT) ? "." : "=";
                        if (c == follow)
                        begin
                            kind = (mode == MODE_QUESTION) ? K_QEQ
                                 : (mode == MODE_DOT) ? K_SPREAD : K_PLUSEQ;
                            add_token(kind, pend_line, pend_start, 2);
                            mode = MODE_IDLE;
                        end
                        else
                        begin
                            if (mode == MODE_PLUS)
                                add_token(K_PLUS, pend_line, pend_start, 1);
                            rescan = 1'b1;
                        end
                    end
                    MODE_SLASH:
                    begin
                        if (c == "/")
                            mode = MODE_LINE_COMMENT;
                        else if (c == "*")
                            mode = MODE_BLOCK_COMMENT;
                        else
                        begin
                            add_token(K_DIV, pend_line, pend_start, 1);
                            rescan = 1'b1;
                        end
                    end
                    MODE_LINE_COMMENT:
                    begin
                        if (c == 8'h0A)
                            rescan = 1'b1;
                    end
                    MODE_BLOCK_COMMENT, MODE_BLOCK_STAR:
                    begin
                        if (mode == MODE_BLOCK_STAR && c == "/")
                            mode = MODE_IDLE;
                        else if (c == "*")
                            mode = MODE_BLOCK_STAR;
                        else
                        begin
                            if (c == 8'h0A)
                                line_count++;
                            mode = MODE_BLOCK_COMMENT;
                        end
                    end
                    default: rescan = 1'b1;
                endcase
                if (rescan)
                    scan_fresh(c);
                byte_pos++;
            end
            if (run_q.size() > 0)
            begin
                t = run_q.pop_back();
                t.last_of_run = 1'b1;
                run_q.push_back(t);
            end
            foreach (run_q[i])
                pending_tokens.push_back(run_q[i]);
        endfunction

        task report(string msg);
            if (errors < 30)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_token(tok_item_t got);
            tok_item_t want;
            if (pending_tokens.size() == 0)
            begin
                report($sformatf("unexpected token kind %0d start %0d",
                                 got.token_kind, got.start_pos));
                return;
            end
            want = pending_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report($sformatf("kind got %0d want %0d at start %0d",
                                 got.token_kind, want.token_kind, want.start_pos));
            if (got.token_line !== want.token_line)
                report($sformatf("line got %0d want %0d at start %0d",
                                 got.token_line, want.token_line, want.start_pos));
            if (got.start_pos !== want.start_pos)
                report($sformatf("start got %0d want %0d",
                                 got.start_pos, want.start_pos));
            if (got.token_length !== want.token_length)
                report($sformatf("length got %0d want %0d at start %0d",
                                 got.token_length, want.token_length, want.start_pos));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last flag got %0b want %0b at start %0d",
                                 got.last_of_run, want.last_of_run, want.start_pos));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_stall;
    src_item_t  src_item = '0;
    logic       tok_valid;
    logic       tok_stall = 1'b0;
    tok_item_t  tok_item;

    int   src_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   phase_no = -1;
    int   items_sent = 0;
    int   cycle_count = 0;
    logic hold_off = 1'b0;
    token_ledger ledger;

    source_character_lexer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
        tok_stall <= hold_off || ($urandom_range(99) < rcv_idle_pct);

    always @(negedge clk)
        if (rst_n && tok_valid && !tok_stall)
            ledger.check_token(tok_item);

    // hold the output side off long enough for the token queue to fill
    initial
    begin
        wait (phase_no == 2);
        repeat (30) @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    task send_item(input logic [7:0] b, input logic eoi);
        src_item_t it;
        bit taken;
        it.source_byte = b;
        it.end_of_input = eoi;
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item <= it;
        do
        begin
            @(negedge clk);
            taken = !src_stall;
            @(posedge clk);
        end
        while (!taken);
        ledger.note_byte(it);
        items_sent++;
    endtask

    task send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] word_char(bit first);
        int k;
        k = first ? $urandom_range(52) : $urandom_range(62);
        if (k < 26)
            return "a" + 8'(k);
        if (k < 52)
            return "A" + 8'(k - 26);
        if (k == 52)
            return "_";
        return "0" + 8'(k - 53);
    endfunction

    task send_lexeme();
        int pick;
        int n;
        int i;
        int ws;
        pick = $urandom_range(99);
        if (pick < 14)
        begin
            case ($urandom_range(7))
                0: send_text("int");
                1: send_text("uint8");
                2: send_text("uint");
                3: send_text("in");
                4: send_text("uint8_");
                default:
                begin
                    n = ($urandom_range(299) == 0) ? $urandom_range(250, 262)
                                                   : $urandom_range(1, 8);
                    send_item(word_char(1'b1), 1'b0);
                    for (i = 1; i < n; i++)
                        send_item(word_char(1'b0), 1'b0);
                end
            endcase
        end
        else if (pick < 24)
        begin
            n = ($urandom_range(299) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                send_item("0" + 8'($urandom_range(9)), 1'b0);
        end
        else if (pick < 34)
        begin
            ws = $urandom_range(8, 13);
            send_item((ws == 8) ? " " : 8'(ws), 1'b0);
        end
        else if (pick < 56)
        begin
            case ($urandom_range(10))
                0: send_text(";");
                1: send_text("=");
                2: send_text("[");
                3: send_text("]");
                4: send_text("+");
                5: send_text("+=");
                6: send_text("/");
                7: send_text("?=");
                8: send_text("..");
                9: send_text("?");
                default: send_text(".");
            endcase
        end
        else if (pick < 63)
        begin
            send_text("//");
            n = $urandom_range(0, 10);
            for (i = 0; i < n; i++)
                send_item(8'($urandom_range(255)), 1'b0);
            send_item(8'h0A, 1'b0);
        end
        else if (pick < 71)
        begin
            send_text("/*");
            n = $urandom_range(0, 12);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(4))
                    0: send_item("*", 1'b0);
                    1: send_item("/", 1'b0);
                    2: send_item(8'h0A, 1'b0);
                    default: send_item(8'($urandom_range(255)), 1'b0);
                endcase
            end
            send_text("*/");
        end
        else if (pick < 74)
        begin
            send_text($urandom_range(1) ? "/*" : "//");
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                send_item(8'($urandom_range(255)), 1'b0);
            send_item(8'($urandom_range(255)), 1'b1);
        end
        else if (pick < 96)
            send_item(8'($urandom_range(255)), 1'b0);
        else
            send_item(8'($urandom_range(255)), 1'b1);
    endtask

    initial
    begin
        ledger = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 32;
        rcv_idle_pct <= 72;
        send_text("int;uint8+=9?=..[]=/*/\n*/?.");
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b0);
        send_text("//\n+");
        send_item(8'hFF, 1'b1);
        send_text("/*");
        send_item(8'h00, 1'b1);
        send_text("x?");
        send_item(8'h00, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            phase_no = p;
            src_idle_pct = (p == 0) ? 32 : (p == 1) ? 72 : 0;
            rcv_idle_pct <= (p == 0) ? 72 : (p == 1) ? 32 : 0;
            while (items_sent < 400 * (p + 1))
                send_lexeme();
        end
        send_item(8'($urandom_range(255)), 1'b1);
        src_valid <= 1'b0;

        while (ledger.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (ledger.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
rtl/slu_pkg.sv
rtl/slu_front.sv
rtl/slu_queue.sv
rtl/slu_back.sv
rtl/source_character_lexer_unit.sv
tb/sv/source_character_lexer_unit_tb.sv
